FILE: rtl/weighted_graph_influence_propagation_defines.svh
// Assertion macros for the influence propagation block.
// Used by the port checker; expects i_clk and i_rst_n in scope.
`ifndef WEIGHTED_GRAPH_INFLUENCE_PROPAGATION_DEFINES_SVH
`define WEIGHTED_GRAPH_INFLUENCE_PROPAGATION_DEFINES_SVH

// Check a property at every clock edge outside of reset.
`define WGIP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define WGIP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/wgip_pkg.sv
// Shared types and constants of the influence propagation block.
// No dependencies; imported by the cell, sequencer, top level, checker and testbench.
package wgip_pkg;

    // Field widths and fixed-point format
    localparam int IDX_FIELD_W = 6;
    localparam int WGT_W       = 16;
    localparam int INF_W       = 32;
    localparam int FRAC_BITS   = 14;
    localparam int ROUND_HALF  = 8192;

    localparam logic signed [INF_W-1:0] INF_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [INF_W-1:0] INF_MIN = 32'sh8000_0000;

    // Configuration register indexes
    localparam logic [1:0] CFG_CONCEPT_COUNT  = 2'd0;
    localparam logic [1:0] CFG_TARGET_CONCEPT = 2'd1;
    localparam logic [1:0] CFG_STEP_COUNT     = 2'd2;
    localparam logic [1:0] CFG_DIRECTION      = 2'd3;

    // One matrix entry
    typedef struct packed {
        logic [IDX_FIELD_W-1:0]  source_index;
        logic [IDX_FIELD_W-1:0]  dest_index;
        logic signed [WGT_W-1:0] edge_weight;
        logic                    load_last;
    } t_item;

    // One concept result
    typedef struct packed {
        logic [IDX_FIELD_W-1:0]  concept_index;
        logic signed [INF_W-1:0] influence_value;
        logic                    target_found;
        logic                    result_last;
    } t_result;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic                    wr;
        logic [IDX_FIELD_W-1:0]  source_index;
        logic [IDX_FIELD_W-1:0]  dest_index;
        logic signed [WGT_W-1:0] edge_weight;
        logic                    rd_target;
        logic [IDX_FIELD_W-1:0]  target;
        logic                    dir;
        logic                    found;
        logic                    seed;
        logic                    shift;
        logic                    acc_init;
        logic                    acc_add;
        logic                    fin;
    } t_cell_ctrl;

endpackage

FILE: rtl/wgip_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module wgip_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/wgip_cell.sv
// One concept cell: holds a matrix row and column, its influence and accumulator.
// Depends on wgip_pkg and wgip_ram.
module wgip_cell #(
    parameter int MAX_CONCEPTS = 64,
    parameter int CELL_IDX     = 0,
    localparam int IDX_W       = $clog2(MAX_CONCEPTS)
) (
    input  logic                     i_clk,
    input  wgip_pkg::t_cell_ctrl     i_ctrl,
    input  logic [IDX_W-1:0]         i_last_idx,
    input  logic signed [31:0]       i_next_x,
    input  logic [IDX_W-1:0]         i_next_a,
    input  logic signed [31:0]       i_head_x,
    input  logic [IDX_W-1:0]         i_head_a,
    output logic signed [31:0]       o_x,
    output logic [IDX_W-1:0]         o_a
);
    import wgip_pkg::*;

    localparam int PROD_W = WGT_W + INF_W;
    localparam int ACC_W  = PROD_W + IDX_W + 1;
    localparam int Q_W    = ACC_W - FRAC_BITS;
    localparam logic signed [Q_W-1:0] SAT_HI = Q_W'(INF_MAX);
    localparam logic signed [Q_W-1:0] SAT_LO = Q_W'(INF_MIN);

    logic signed [INF_W-1:0]  r_x;
    logic [IDX_W-1:0]         r_a;
    logic signed [INF_W-1:0]  r_x_d;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    logic                     row_we;
    logic                     col_we;
    logic [IDX_W-1:0]         rd_addr;
    logic [WGT_W-1:0]         row_rdata;
    logic [WGT_W-1:0]         col_rdata;
    logic signed [WGT_W-1:0]  weight;
    logic                     is_last;
    logic signed [INF_W-1:0]  ring_x;
    logic [IDX_W-1:0]         ring_a;
    logic signed [INF_W-1:0]  seed_x;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic signed [Q_W-1:0]    acc_q;
    logic signed [INF_W-1:0]  sat_x;

    // Row copy keyed by source, column copy keyed by destination
    assign row_we = i_ctrl.wr && (32'(i_ctrl.source_index) == CELL_IDX)
                    && (32'(i_ctrl.dest_index) < MAX_CONCEPTS);
    assign col_we = i_ctrl.wr && (32'(i_ctrl.dest_index) == CELL_IDX)
                    && (32'(i_ctrl.source_index) < MAX_CONCEPTS);
    assign rd_addr = i_ctrl.rd_target ? IDX_W'(i_ctrl.target) : r_a;

    wgip_ram #(.WIDTH(WGT_W), .DEPTH(MAX_CONCEPTS)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (IDX_W'(i_ctrl.dest_index)),
        .i_wdata (i_ctrl.edge_weight),
        .i_raddr (rd_addr),
        .o_rdata (row_rdata)
    );

    wgip_ram #(.WIDTH(WGT_W), .DEPTH(MAX_CONCEPTS)) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (IDX_W'(i_ctrl.source_index)),
        .i_wdata (i_ctrl.edge_weight),
        .i_raddr (rd_addr),
        .o_rdata (col_rdata)
    );

    assign weight = $signed(i_ctrl.dir ? col_rdata : row_rdata);

    // Close the ring at the last concept in use
    assign is_last = (i_last_idx == IDX_W'(CELL_IDX));
    assign ring_x  = is_last ? i_head_x : i_next_x;
    assign ring_a  = is_last ? i_head_a : i_next_a;

    // Seed is the weight scaled by four, zero when the target is absent
    assign seed_x = i_ctrl.found ? (INF_W'(weight) <<< 2) : '0;

    // Round half up to Q.14, then saturate to 32 bits
    assign acc_rnd = r_acc + ACC_W'(ROUND_HALF);
    assign acc_q   = $signed(acc_rnd[ACC_W-1:FRAC_BITS]);
    always_comb begin
        if (acc_q > SAT_HI) begin
            sat_x = INF_MAX;
        end else if (acc_q < SAT_LO) begin
            sat_x = INF_MIN;
        end else begin
            sat_x = acc_q[INF_W-1:0];
        end
    end

    // Multiply stage: weight read in step with the delayed ring value
    always_ff @(posedge i_clk) begin
        r_x_d  <= r_x;
        r_prod <= weight * r_x_d;
    end

    // Ring value and its concept index
    always_ff @(posedge i_clk) begin
        if (i_ctrl.seed) begin
            r_x <= seed_x;
            r_a <= IDX_W'(CELL_IDX);
        end else if (i_ctrl.fin) begin
            r_x <= sat_x;
            r_a <= IDX_W'(CELL_IDX);
        end else if (i_ctrl.shift) begin
            r_x <= ring_x;
            r_a <= ring_a;
        end
    end

    // Accumulate: start from own influence, add one product per cycle while acc_add is set
    always_ff @(posedge i_clk) begin
        if (i_ctrl.acc_init) begin
            r_acc <= ACC_W'(r_x) <<< FRAC_BITS;
        end else if (i_ctrl.acc_add) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_x = r_x;
    assign o_a = r_a;

endmodule

FILE: rtl/wgip_ctrl.sv
// Sequencer: loads entries, runs seed, iterations and result shift-out.
// Depends on wgip_pkg.
module wgip_ctrl #(
    parameter int MAX_CONCEPTS = 64,
    localparam int IDX_W       = $clog2(MAX_CONCEPTS),
    localparam int CNT_W       = $clog2(MAX_CONCEPTS + 1),
    localparam int K_W         = $clog2(MAX_CONCEPTS + 3)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  wgip_pkg::t_item       i_item,
    input  logic [6:0]            i_concept_count,
    input  logic [5:0]            i_target,
    input  logic [7:0]            i_step_count,
    input  logic                  i_direction,
    input  logic signed [31:0]    i_head_x,
    output wgip_pkg::t_cell_ctrl  o_ctrl,
    output logic [IDX_W-1:0]      o_last_idx,
    output logic                  o_result_valid,
    output wgip_pkg::t_result     o_result
);
    import wgip_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SEED_RD = 3'd1;
    localparam logic [2:0] S_SEED_LD = 3'd2;
    localparam logic [2:0] S_ITER    = 3'd3;
    localparam logic [2:0] S_OUT     = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [K_W-1:0]   r_k, n_k;
    logic [7:0]       r_iter, n_iter;
    logic [IDX_W-1:0] r_last_idx, n_last_idx;
    logic             r_found, n_found;
    logic             r_dir, n_dir;
    logic [5:0]       r_target, n_target;
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;

    logic             accept;
    logic [CNT_W-1:0] cnt;
    logic [K_W-1:0]   k_last;
    logic             k_is_last;

    assign accept = i_start && (r_state == S_IDLE);

    // Concepts in use, clipped to the array size
    assign cnt = (32'(i_concept_count) > MAX_CONCEPTS) ? CNT_W'(MAX_CONCEPTS)
                                                       : CNT_W'(i_concept_count);
    assign k_last    = K_W'(r_last_idx);
    assign k_is_last = (r_k == k_last);

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_iter      = r_iter;
        n_last_idx  = r_last_idx;
        n_found     = r_found;
        n_dir       = r_dir;
        n_target    = r_target;
        n_out_valid = 1'b0;
        n_out       = r_out;

        o_ctrl              = '0;
        o_ctrl.wr           = accept;
        o_ctrl.source_index = i_item.source_index;
        o_ctrl.dest_index   = i_item.dest_index;
        o_ctrl.edge_weight  = i_item.edge_weight;
        o_ctrl.target       = r_target;
        o_ctrl.dir          = r_dir;
        o_ctrl.found        = r_found;

        case (r_state)
            S_IDLE: begin
                // Latch the run setup on the closing entry, unless no concepts are in use
                if (accept && i_item.load_last && (cnt != '0)) begin
                    n_last_idx = IDX_W'(cnt - CNT_W'(1));
                    n_found    = (32'(i_target) < 32'(cnt));
                    n_dir      = i_direction;
                    n_target   = i_target;
                    n_iter     = (i_step_count == 8'd0) ? 8'd0 : i_step_count - 8'd1;
                    n_state    = S_SEED_RD;
                end
            end
            S_SEED_RD: begin
                o_ctrl.rd_target = 1'b1;
                n_state          = S_SEED_LD;
            end
            S_SEED_LD: begin
                o_ctrl.seed = 1'b1;
                n_k         = '0;
                n_state     = (r_found && (r_iter != 8'd0)) ? S_ITER : S_OUT;
            end
            S_ITER: begin
                // Rotate the ring once around the concepts in use, drain two pipeline stages, then fold
                o_ctrl.shift    = (r_k <= k_last);
                o_ctrl.acc_init = (r_k == '0);
                o_ctrl.acc_add  = (r_k >= K_W'(2)) && (r_k <= k_last + K_W'(2));
                if (r_k == k_last + K_W'(3)) begin
                    o_ctrl.fin = 1'b1;
                    n_k        = '0;
                    n_iter     = r_iter - 8'd1;
                    if (r_iter == 8'd1) begin
                        n_state = S_OUT;
                    end
                end else begin
                    n_k = r_k + K_W'(1);
                end
            end
            S_OUT: begin
                // Take the head of the ring, one concept per cycle
                o_ctrl.shift          = 1'b1;
                n_out_valid           = 1'b1;
                n_out.concept_index   = IDX_FIELD_W'(r_k);
                n_out.influence_value = i_head_x;
                n_out.target_found    = r_found;
                n_out.result_last     = k_is_last;
                n_k                   = r_k + K_W'(1);
                if (k_is_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

    // Run setup and result payload
    always_ff @(posedge i_clk) begin
        r_last_idx <= n_last_idx;
        r_found    <= n_found;
        r_dir      <= n_dir;
        r_target   <= n_target;
        r_out      <= n_out;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_last_idx     = r_last_idx;
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

FILE: rtl/weighted_graph_influence_propagation.sv
// Influence propagation over a weighted concept graph: top level.
// Depends on wgip_pkg, wgip_ram, wgip_cell and wgip_ctrl.
//
// Usage:
//   Write the four registers through i_cfg_we / i_cfg_addr / i_cfg_wdata
//   while busy is low. Then send the weight matrix as transactions: one
//   entry is accepted at each clock edge where start is high and busy is
//   low, so entries can stream one per cycle. The entry with load_last
//   set is stored too and then starts the run (busy rises), if any concepts
//   are in use. The run seeds first; then in each iteration the ring of
//   n cells (n = concepts in use) rotates the influence vector past each
//   cell's row or column memory, one product per cell per cycle, through
//   the multiply and accumulate pipeline. A run makes step_count-1
//   iterations, none with step_count below 2 or the target absent.
//   Results follow one per cycle, n in all, on o_result with o_result_valid
//   high for one cycle each; the last one shows result_last.
//   The receiver cannot stall; every result is taken when shown.
//   Reset clears the sequencer and the registers; the matrix memories
//   keep whatever they held and must be written before they are read.
module weighted_graph_influence_propagation #(
    parameter int MAX_CONCEPTS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_addr,
    input  logic [7:0]          i_cfg_wdata,
    input  logic                start,
    output logic                busy,
    input  wgip_pkg::t_item     i_item,
    output logic                o_result_valid,
    output wgip_pkg::t_result   o_result
);
    import wgip_pkg::*;

    localparam int IDX_W = $clog2(MAX_CONCEPTS);

    logic [6:0] r_concept_count;
    logic [5:0] r_target_concept;
    logic [7:0] r_step_count;
    logic       r_direction;

    t_cell_ctrl              cell_ctrl;
    logic [IDX_W-1:0]        last_idx;
    logic signed [INF_W-1:0] cell_x [MAX_CONCEPTS];
    logic [IDX_W-1:0]        cell_a [MAX_CONCEPTS];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_concept_count  <= 7'd1;
            r_target_concept <= 6'd0;
            r_step_count     <= 8'd1;
            r_direction      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CONCEPT_COUNT:  r_concept_count  <= i_cfg_wdata[6:0];
                CFG_TARGET_CONCEPT: r_target_concept <= i_cfg_wdata[5:0];
                CFG_STEP_COUNT:     r_step_count     <= i_cfg_wdata;
                CFG_DIRECTION:      r_direction      <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    wgip_ctrl #(.MAX_CONCEPTS(MAX_CONCEPTS)) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_item          (i_item),
        .i_concept_count (r_concept_count),
        .i_target        (r_target_concept),
        .i_step_count    (r_step_count),
        .i_direction     (r_direction),
        .i_head_x        (cell_x[0]),
        .o_ctrl          (cell_ctrl),
        .o_last_idx      (last_idx),
        .o_result_valid  (o_result_valid),
        .o_result        (o_result)
    );

    // Ring of cells; each takes its neighbor's value, the last wraps to the head
    for (genvar gi = 0; gi < MAX_CONCEPTS; gi++) begin : g_cell
        localparam int NEXT = (gi + 1) % MAX_CONCEPTS;
        wgip_cell #(.MAX_CONCEPTS(MAX_CONCEPTS), .CELL_IDX(gi)) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (cell_ctrl),
            .i_last_idx (last_idx),
            .i_next_x   (cell_x[NEXT]),
            .i_next_a   (cell_a[NEXT]),
            .i_head_x   (cell_x[0]),
            .i_head_a   (cell_a[0]),
            .o_x        (cell_x[gi]),
            .o_a        (cell_a[gi])
        );
    end

endmodule

FILE: rtl/wgip_chk.sv
// Port checker for the influence propagation block, bound to the top level.
// Depends on wgip_pkg and the assertion macro header.
`include "weighted_graph_influence_propagation_defines.svh"

module wgip_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input wgip_pkg::t_item   i_item,
    input logic              o_result_valid,
    input wgip_pkg::t_result o_result
);
    import wgip_pkg::*;

    logic                 mid_result;
    logic [IDX_FIELD_W:0] shown;
    logic [IDX_FIELD_W:0] follow;

    // Found flag and index as shown, and as the next result of the run must show them
    assign mid_result = o_result_valid && !o_result.result_last;
    assign shown      = {o_result.target_found, o_result.concept_index};
    assign follow     = {o_result.target_found, o_result.concept_index + IDX_FIELD_W'(1)};

    // Reset leaves the block idle with no result strobe
    `WGIP_ASSERT_RST(a_reset_idle, !i_rst_n |=> (!busy && !o_result_valid), "reset not idle")

    // A result shown while idle can only be the closing one
    `WGIP_ASSERT(a_idle_last, (o_result_valid && !busy) |-> o_result.result_last, "stray result")

    // Nothing follows the closing result
    `WGIP_ASSERT(a_last_ends, (o_result_valid && o_result.result_last) |=> !o_result_valid, "extra result")

    // Results of one run come back to back in index order with one found flag
    `WGIP_ASSERT(a_order, mid_result |=> (o_result_valid && shown == $past(follow)), "result order broken")

    // A plain matrix entry does not start a run
    `WGIP_ASSERT(a_load_only, (start && !busy && !i_item.load_last) |=> !busy, "run started early")

endmodule

bind weighted_graph_influence_propagation wgip_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_item         (i_item),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the weighted graph influence propagation block.
// Needs wgip_pkg and the RTL; a built-in predictor checks every result transaction.

module tb_top;
    import wgip_pkg::*;

    localparam int MAXC            = 64;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RANDOM_ENTRIES  = 500;
    localparam int WATCHDOG_LIMIT  = 60000;

    typedef enum logic {ROW_CFG, ROW_ENTRY} t_row_kind;

    // One line of the bring-up table
    typedef struct {
        t_row_kind               kind;
        logic [1:0]              reg_idx;
        logic [7:0]              reg_val;
        t_item                   entry;
        bit                      typed;
        logic signed [INF_W-1:0] typed_inf;
        logic                    typed_found;
    } t_bringup_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_addr;
    logic [7:0] i_cfg_wdata;
    logic       start;
    logic       busy;
    t_item      i_item;
    logic       o_result_valid;
    t_result    o_result;

    // Predictor state: weight matrix, which entries hold data, register copies
    logic signed [WGT_W-1:0] edge_mem [MAXC*MAXC];
    bit                      edge_set [MAXC*MAXC];
    logic [6:0]              cfg_count  = 7'd1;
    logic [5:0]              cfg_target = 6'd0;
    logic [7:0]              cfg_steps  = 8'd1;
    logic                    cfg_dir    = 1'b0;

    t_result      influence_due [$];
    t_bringup_row bringup [$];
    bit           mismatch_seen = 1'b0;
    int           entries_sent  = 0;
    int           quiet_cycles  = 0;
    bit           burst         = 1'b0;

    weighted_graph_influence_propagation #(.MAX_CONCEPTS(MAXC)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Matrix entry seen through the selected direction
    function automatic longint weight_of(input int row, input int col);
        if (cfg_dir) begin
            return longint'(edge_mem[col * MAXC + row]);
        end
        return longint'(edge_mem[row * MAXC + col]);
    endfunction

    // Q.28 sum to Q.14, round half up, clamp to the 32-bit rails
    function automatic logic signed [INF_W-1:0] round_q14(input longint total);
        longint q;
        q = (total + ROUND_HALF) >>> FRAC_BITS;
        if (q > longint'(INF_MAX)) return INF_MAX;
        if (q < longint'(INF_MIN)) return INF_MIN;
        return q[INF_W-1:0];
    endfunction

    function automatic bit block_ready(input int n);
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                if (!edge_set[r * MAXC + c]) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Seed from the target, iterate, and queue one result per concept in use
    function automatic void predict_influence(input bit typed,
                                              input logic signed [INF_W-1:0] typed_inf,
                                              input logic typed_found);
        int                      n;
        bit                      found;
        longint                  acc;
        logic signed [INF_W-1:0] vec [MAXC];
        logic signed [INF_W-1:0] nxt [MAXC];
        t_result                 res;
        n = (cfg_count > MAXC) ? MAXC : int'(cfg_count);
        if (n == 0) return;
        found = (cfg_target < n);
        for (int i = 0; i < n; i++) begin
            vec[i] = found ? INF_W'(weight_of(i, int'(cfg_target)) * 4) : '0;
        end
        if (found) begin
            for (int s = 1; s < int'(cfg_steps); s++) begin
                for (int i = 0; i < n; i++) begin
                    acc = longint'(vec[i]) <<< FRAC_BITS;
                    for (int j = 0; j < n; j++) begin
                        acc += weight_of(i, j) * longint'(vec[j]);
                    end
                    nxt[i] = round_q14(acc);
                end
                for (int i = 0; i < n; i++) vec[i] = nxt[i];
            end
        end
        for (int i = 0; i < n; i++) begin
            res.concept_index   = IDX_FIELD_W'(i);
            res.influence_value = typed ? typed_inf : vec[i];
            res.target_found    = typed ? typed_found : found;
            res.result_last     = (i == n - 1);
            influence_due.push_back(res);
        end
    endfunction

    function automatic t_item make_entry(input int src, input int dst,
                                         input logic [WGT_W-1:0] w, input bit last);
        t_item e;
        e.source_index = IDX_FIELD_W'(src);
        e.dest_index   = IDX_FIELD_W'(dst);
        e.edge_weight  = w;
        e.load_last    = last;
        return e;
    endfunction

    // Mostly sparse and small weights, with the rails and raw patterns mixed in
    function automatic logic [WGT_W-1:0] pick_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return '0;
        if (r < 65) return WGT_W'($urandom_range(0, 4095) - 2048);
        if (r < 85) return WGT_W'($urandom_range(0, 32768) - 16384);
        if (r < 92) begin
            case ($urandom_range(0, 3))
                0:       return 16'h4000;
                1:       return 16'hC000;
                2:       return 16'h7FFF;
                default: return 16'h8000;
            endcase
        end
        return WGT_W'($urandom());
    endfunction

    function automatic int pick_index(input int n);
        if (n > 0 && $urandom_range(0, 4) != 0) return $urandom_range(0, n - 1);
        return $urandom_range(0, MAXC - 1);
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void row_cfg(input logic [1:0] idx, input logic [7:0] val);
        t_bringup_row row;
        row         = '{kind: ROW_CFG, default: '0};
        row.kind    = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = val;
        bringup.push_back(row);
    endfunction

    function automatic void row_entry(input int src, input int dst,
                                      input logic [WGT_W-1:0] w, input bit last,
                                      input bit typed = 1'b0,
                                      input logic signed [INF_W-1:0] inf = '0,
                                      input logic found = 1'b0);
        t_bringup_row row;
        row             = '{kind: ROW_ENTRY, default: '0};
        row.kind        = ROW_ENTRY;
        row.entry       = make_entry(src, dst, w, last);
        row.typed       = typed;
        row.typed_inf   = inf;
        row.typed_found = found;
        bringup.push_back(row);
    endfunction

    function automatic void check_field(input string label, input logic [INF_W-1:0] want,
                                        input logic [INF_W-1:0] got);
        if (got !== want) begin
            mismatch_seen = 1'b1;
            $error("%s: expected %0d, got %0d", label, $signed(want), $signed(got));
        end
    endfunction

    // Drive one entry transaction and hold it until the block takes it
    task automatic send_entry(input t_item entry, input bit typed = 1'b0,
                              input logic signed [INF_W-1:0] typed_inf = '0,
                              input logic typed_found = 1'b0);
        int gap;
        int slot;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= entry;
        do @(posedge i_clk); while (busy);
        slot           = int'(entry.source_index) * MAXC + int'(entry.dest_index);
        edge_mem[slot] = entry.edge_weight;
        edge_set[slot] = 1'b1;
        entries_sent++;
        if (entry.load_last) predict_influence(typed, typed_inf, typed_found);
    endtask

    // Drop start, drain pending results, then let the sequencer settle
    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (influence_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_CONCEPT_COUNT:  cfg_count  = val[6:0];
            CFG_TARGET_CONCEPT: cfg_target = val[5:0];
            CFG_STEP_COUNT:     cfg_steps  = val;
            CFG_DIRECTION:      cfg_dir    = val[0];
            default: ;
        endcase
    endtask

    // One load: full matrix, a patch and restart, or stray writes only
    task automatic run_sequence();
        int n;
        int r;
        int row;
        int col;
        int patches;
        bit by_column;
        n = (cfg_count > MAXC) ? MAXC : int'(cfg_count);
        r = $urandom_range(0, 99);
        if (!block_ready(n) || (n <= 16 && r < 50)) begin
            by_column = $urandom_range(0, 1);
            if (n == 0) begin
                send_entry(make_entry(pick_index(0), pick_index(0), pick_weight(), 1'b1));
            end
            for (int k = 0; k < n * n; k++) begin
                row = by_column ? k % n : k / n;
                col = by_column ? k / n : k % n;
                send_entry(make_entry(row, col, pick_weight(), k == n * n - 1));
            end
        end else if (r < 85) begin
            patches = $urandom_range(0, (n * n / 2 < 24) ? n * n / 2 : 24);
            repeat (patches) begin
                send_entry(make_entry(pick_index(n), pick_index(n), pick_weight(), 1'b0));
            end
            send_entry(make_entry(pick_index(n), pick_index(n), pick_weight(), 1'b1));
        end else begin
            repeat ($urandom_range(1, 8)) begin
                send_entry(make_entry($urandom_range(0, MAXC - 1), $urandom_range(0, MAXC - 1),
                                      WGT_W'($urandom()), 1'b0));
            end
        end
    endtask

    // Reprogram while idle (unchanged registers now and then too), then load
    task automatic run_phase(input int cnt, input int tgt, input int steps, input int dir_sel);
        wait_idle();
        if (cnt != int'(cfg_count) || $urandom_range(0, 1)) begin
            write_reg(CFG_CONCEPT_COUNT, 8'(cnt));
        end
        if (tgt != int'(cfg_target) || $urandom_range(0, 1)) begin
            write_reg(CFG_TARGET_CONCEPT, 8'(tgt));
        end
        if (steps != int'(cfg_steps) || $urandom_range(0, 1)) begin
            write_reg(CFG_STEP_COUNT, 8'(steps));
        end
        if (dir_sel != int'(cfg_dir) || $urandom_range(0, 1)) begin
            write_reg(CFG_DIRECTION, 8'(dir_sel));
        end
        burst = ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(1, 3)) begin
            if (entries_sent < RANDOM_ENTRIES) run_sequence();
        end
    endtask

    // Compare each result transaction with the oldest pending one
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            if (influence_due.size() == 0) begin
                mismatch_seen = 1'b1;
                $error("result for concept %0d with nothing pending",
                       o_result.concept_index);
            end else begin
                want = influence_due.pop_front();
                check_field("concept_index", INF_W'(want.concept_index),
                            INF_W'(o_result.concept_index));
                check_field("influence_value", want.influence_value,
                            o_result.influence_value);
                check_field("target_found", INF_W'(want.target_found),
                            INF_W'(o_result.target_found));
                check_field("result_last", INF_W'(want.result_last),
                            INF_W'(o_result.result_last));
            end
        end
    end

    // Stop a hung run: count cycles with no transaction either way
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (start && !busy) || o_result_valid) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int r;
        int cnt;
        int tgt;
        int steps;
        int dir_sel;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_wdata = '0;
        start       = 1'b0;
        i_item      = '0;

        // After reset: one concept, target 0, one step, toward the target
        row_entry(0, 0, 16'h4000, 1'b1, 1'b1, 32'sh0001_0000, 1'b1);
        row_entry(0, 0, 16'h8000, 1'b1, 1'b1, -32'sd131072, 1'b1);
        row_entry(0, 0, 16'h7FFF, 1'b1, 1'b1, 32'sh0001_FFFC, 1'b1);
        // zero steps emits the seed
        row_cfg(CFG_STEP_COUNT, 8'd0);
        row_entry(0, 0, 16'h0001, 1'b1, 1'b1, 32'sd4, 1'b1);
        // deepest propagation climbs to the positive rail
        row_cfg(CFG_STEP_COUNT, 8'd255);
        row_entry(0, 0, 16'h7FFF, 1'b1);
        // target beyond the concepts in use: zeros, not found
        row_cfg(CFG_CONCEPT_COUNT, 8'd2);
        row_cfg(CFG_TARGET_CONCEPT, 8'd5);
        row_cfg(CFG_STEP_COUNT, 8'd3);
        row_entry(0, 0, 16'h7FFF, 1'b0);
        row_entry(0, 1, 16'h8000, 1'b0);
        row_entry(1, 0, 16'h0000, 1'b0);
        row_entry(1, 1, 16'h7FFF, 1'b1, 1'b1, 32'sd0, 1'b0);
        // concept 0 is driven to the negative rail
        row_cfg(CFG_TARGET_CONCEPT, 8'd1);
        row_cfg(CFG_STEP_COUNT, 8'd255);
        row_entry(1, 1, 16'h7FFF, 1'b1);
        // transposed matrix
        row_cfg(CFG_DIRECTION, 8'd1);
        row_cfg(CFG_STEP_COUNT, 8'd4);
        row_entry(0, 1, 16'h2000, 1'b1);
        row_cfg(CFG_STEP_COUNT, 8'd1);
        row_entry(1, 0, 16'hC000, 1'b1);
        // no concepts in use: nothing comes back
        row_cfg(CFG_CONCEPT_COUNT, 8'd0);
        row_entry(1, 0, 16'h1234, 1'b1);
        // highest target index with one concept is out of range
        row_cfg(CFG_CONCEPT_COUNT, 8'd1);
        row_cfg(CFG_TARGET_CONCEPT, 8'd63);
        row_cfg(CFG_DIRECTION, 8'd0);
        row_entry(0, 0, 16'h0100, 1'b1, 1'b1, 32'sd0, 1'b0);
        // far corners of the matrix, no run
        row_entry(63, 63, 16'hFFFF, 1'b0);
        row_entry(63, 0, 16'h5555, 1'b0);
        row_entry(0, 63, 16'hAAAA, 1'b0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (bringup[k]) begin
            if (bringup[k].kind == ROW_CFG) begin
                wait_idle();
                write_reg(bringup[k].reg_idx, bringup[k].reg_val);
            end else begin
                send_entry(bringup[k].entry, bringup[k].typed, bringup[k].typed_inf,
                           bringup[k].typed_found);
            end
        end

        // Random phases on small graphs
        while (entries_sent < RANDOM_ENTRIES) begin
            r   = $urandom_range(0, 99);
            cnt = (r < 5) ? 0 : (r < 80) ? $urandom_range(1, 6) : $urandom_range(7, 16);
            tgt = (cnt > 0 && $urandom_range(0, 4) != 0) ? $urandom_range(0, cnt - 1)
                                                         : $urandom_range(0, MAXC - 1);
            r     = $urandom_range(0, 99);
            steps = (r < 10) ? $urandom_range(0, 1) :
                    (r < 75) ? $urandom_range(2, 5) :
                    (r < 95) ? $urandom_range(6, 20) : $urandom_range(21, 255);
            dir_sel = $urandom_range(0, 1);
            run_phase(cnt, tgt, steps, dir_sel);
        end

        wait_idle();
        repeat (SETTLE_CYCLES * 4) @(posedge i_clk);
        if (!mismatch_seen) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
